/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/phss_pkg.sv */
// Shared types and constants of the hue/saturation colorize block.
package phss_pkg;

  localparam int ChanW  = 8;    // pixel channel width
  localparam int CfgW   = 7;    // hue / saturation register width
  localparam int ApbAw  = 3;    // two registers at byte offsets 0 and 4
  localparam int ApbDw  = 32;
  localparam int KW     = 14;   // signed weight 5000 - S*d, range -1350..5000
  localparam int XW     = 18;   // positive numerator over 8, below 2^18
  localparam int MagicW = 19;

  // numerators carry a common denominator of 5000
  localparam logic [KW-1:0] FullScale = KW'(5000);
  localparam logic [5:0]    HalfHue   = 6'd50;

  // floor(x / 625) = (x * Magic) >> MagicShift for every x below 2^18
  localparam logic [MagicW-1:0] Magic = MagicW'(429497);
  localparam int MagicShift = 28;

  typedef enum logic {
    RegHue = 1'b0,
    RegSat = 1'b1
  } cfg_reg_e;

endpackage

/* design/phss_in_if.sv */
// Input pixel channel: valid/ready handshake with an RGB payload.
interface phss_in_if;
  import phss_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

/* design/phss_out_if.sv */
// Output pixel channel: valid/ready handshake with an RGB payload.
interface phss_out_if;
  import phss_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

/* design/pixel_hue_saturation_set_top.sv */
// Throughput: one pixel per cycle; the three stages advance together and
// hold while the output register is full and pix_o.ready is low.
// Stage 1 takes the channel peak and weights, 2 multiplies it by the channel weight,
// 3 divides by 5000 through a reciprocal multiply.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears both registers.
`include "assert_macros.svh"

module pixel_hue_saturation_set_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  phss_in_if.sink                    pix_i,
  phss_out_if.source                 pix_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [phss_pkg::ApbAw-1:0] paddr,
  input  logic [phss_pkg::ApbDw-1:0] pwdata,
  output logic [phss_pkg::ApbDw-1:0] prdata,
  output logic                       pready
);
  import phss_pkg::*;

  typedef enum logic [2:0] {
    SecRed2Yel = 3'd0,
    SecYel2Grn = 3'd1,
    SecGrn2Cyn = 3'd2,
    SecCyn2Blu = 3'd3,
    SecBlu2Mag = 3'd4,
    SecMag2Red = 3'd5
  } sector_e;

  // ---------------- configuration registers ----------------
  logic [CfgW-1:0] hue_q, sat_q;
  logic            cfg_wr;
  cfg_reg_e        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= '0;
      sat_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegHue:  hue_q <= pwdata[CfgW-1:0];
        RegSat:  sat_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (cfg_sel)
        RegHue:  prdata = ApbDw'(hue_q);
        RegSat:  prdata = ApbDw'(sat_q);
        default: prdata = '0;
      endcase
    end
  end

  // ---------------- hue decode (static between config writes) ----------------
  logic [8:0] hue3;     // 3 * hue_percent, hue in units of 60/50 degrees
  logic [6:0] hue_t;    // hue3 mod 100
  logic [5:0] hue_dev;  // |hue_t - 50|
  sector_e    sector;
  logic [5:0] d_r, d_g, d_b;  // 0 -> chroma, hue_dev -> second, 50 -> zero

  assign hue3 = {hue_q, 1'b0} + 9'(hue_q);

  always_comb begin
    if      (hue3 < 9'd50)  sector = SecRed2Yel;
    else if (hue3 < 9'd100) sector = SecYel2Grn;
    else if (hue3 < 9'd150) sector = SecGrn2Cyn;
    else if (hue3 < 9'd200) sector = SecCyn2Blu;
    else if (hue3 < 9'd250) sector = SecBlu2Mag;
    else                    sector = SecMag2Red;

    if      (hue3 >= 9'd300) hue_t = 7'(hue3 - 9'd300);
    else if (hue3 >= 9'd200) hue_t = 7'(hue3 - 9'd200);
    else if (hue3 >= 9'd100) hue_t = 7'(hue3 - 9'd100);
    else                     hue_t = hue3[6:0];

    hue_dev = (hue_t >= 7'(HalfHue)) ? 6'(hue_t - 7'(HalfHue))
                                     : 6'(7'(HalfHue) - hue_t);

    unique case (sector)
      SecRed2Yel: begin d_r = '0;      d_g = hue_dev; d_b = HalfHue; end
      SecYel2Grn: begin d_r = hue_dev; d_g = '0;      d_b = HalfHue; end
      SecGrn2Cyn: begin d_r = HalfHue; d_g = '0;      d_b = hue_dev; end
      SecCyn2Blu: begin d_r = HalfHue; d_g = hue_dev; d_b = '0;      end
      SecBlu2Mag: begin d_r = hue_dev; d_g = HalfHue; d_b = '0;      end
      default:    begin d_r = '0;      d_g = HalfHue; d_b = hue_dev; end
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [2:0] v_q;
  logic       en;

  assign en          = !v_q[2] || pix_o.ready;
  assign pix_i.ready = en;
  assign pix_o.valid = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], pix_i.valid};
    end
  end

  // ---------------- stage 1: peak and channel weights ----------------
  logic        [ChanW-1:0] peak_d, peak_q;
  logic        [12:0]      sd [3];
  logic signed [KW-1:0]    k_d [3];
  logic signed [KW-1:0]    k_q [3];

  always_comb begin
    peak_d = pix_i.red_in;
    if (pix_i.green_in > peak_d) peak_d = pix_i.green_in;
    if (pix_i.blue_in > peak_d)  peak_d = pix_i.blue_in;

    sd[0] = 13'(sat_q) * 13'(d_r);
    sd[1] = 13'(sat_q) * 13'(d_g);
    sd[2] = 13'(sat_q) * 13'(d_b);
    for (int i = 0; i < 3; i++) begin
      // weight = chroma + component - ... folded: 5000 - S*d
      k_d[i] = $signed(FullScale) - $signed({1'b0, sd[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      peak_q <= peak_d;
      for (int i = 0; i < 3; i++) k_q[i] <= k_d[i];
    end
  end

  // ---------------- stage 2: peak times weight ----------------
  logic signed [22:0]   prod [3];
  logic        [XW-1:0] x_d  [3];
  logic        [XW-1:0] x_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = 23'($signed({1'b0, peak_q}) * k_q[i]);
      // non-positive numerators clamp to zero; positive ones stay below 2^21
      x_d[i]  = (prod[i] > 23'sd0) ? prod[i][20:3] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) x_q[i] <= x_d[i];
    end
  end

  // ---------------- stage 3: divide by 625 (already over 8) ----------------
  logic [XW+MagicW-1:0] quo  [3];
  logic [ChanW-1:0]     ch_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = (XW+MagicW)'(x_q[i]) * (XW+MagicW)'(Magic);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) ch_q[i] <= quo[i][MagicShift +: ChanW];
    end
  end

  assign pix_o.red_out   = ch_q[0];
  assign pix_o.green_out = ch_q[1];
  assign pix_o.blue_out  = ch_q[2];

  // ---------------- assertions ----------------
  `ASSERT_CLK(a_stall_blocks_in, v_q[2] && !pix_o.ready |-> !pix_i.ready, "input taken while output stalled")
  `ASSERT_CLK(a_accept_fills_s1, pix_i.valid && pix_i.ready |=> v_q[0], "accepted pixel lost in stage 1")
  `ASSERT_CLK(a_black_stays_black, en && v_q[0] && peak_q == '0 |=> x_q[0] == '0 && x_q[1] == '0 && x_q[2] == '0, "black pixel gave nonzero numerator")
  `ASSERT_CLK(a_numerator_range, v_q[1] |-> x_q[0] <= 18'd159375 && x_q[1] <= 18'd159375 && x_q[2] <= 18'd159375, "numerator outside reciprocal range")

endmodule

/* bench/tb_colorize_checker.sv */
// Scoreboard for the hue/saturation colorize block: tracks registers, predicts and checks pixels.
`timescale 1ns / 100ps

module tb_colorize_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  phss_in_if                         pix_i,
  phss_out_if                        pix_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [phss_pkg::ApbAw-1:0] paddr,
  input  logic [phss_pkg::ApbDw-1:0] pwdata,
  output int                         errors_o,
  output int                         pending_o
);
  import phss_pkg::*;

  localparam longint PixDen = 5000;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef enum int {
    SecRedYel,
    SecYelGrn,
    SecGrnCyan,
    SecCyanBlue,
    SecBlueMag,
    SecMagRed
  } hue_sector_e;

  logic [CfgW-1:0] hue_cfg;
  logic [CfgW-1:0] sat_cfg;
  pixel_t          pending_pixels[$];
  pixel_t          want;
  pixel_t          got;
  int              mismatches;

  // numerator over 5000 -> channel, truncated toward zero, clamped to 0..255
  function automatic logic [ChanW-1:0] clamp_channel(longint num);
    longint q;
    if (num <= 0) return '0;
    q = num / PixDen;
    if (q > 255) q = 255;
    return ChanW'(q);
  endfunction

  function automatic pixel_t colorize(pixel_t px, logic [CfgW-1:0] hue, logic [CfgW-1:0] sat);
    longint      peak, chroma, second, base, t, hue_dev, hue_l, sat_l;
    longint      r_num, g_num, b_num;
    hue_sector_e sector;
    pixel_t      res;
    peak = longint'(px.red);
    if (longint'(px.green) > peak) peak = longint'(px.green);
    if (longint'(px.blue) > peak) peak = longint'(px.blue);
    hue_l = longint'(hue);
    sat_l = longint'(sat);
    // hue at or past 300 degrees (also 360 and above) stays in the last sector
    sector = ((3 * hue_l) / 50 >= 5) ? SecMagRed : hue_sector_e'((3 * hue_l) / 50);
    t = (3 * hue_l) % 100;
    hue_dev = (t >= 50) ? t - 50 : 50 - t;
    chroma = 50 * peak * sat_l;
    second = peak * sat_l * (50 - hue_dev);
    base = 50 * peak * (100 - sat_l);
    case (sector)
      SecRedYel: begin
        r_num = chroma; g_num = second; b_num = 0;
      end
      SecYelGrn: begin
        r_num = second; g_num = chroma; b_num = 0;
      end
      SecGrnCyan: begin
        r_num = 0; g_num = chroma; b_num = second;
      end
      SecCyanBlue: begin
        r_num = 0; g_num = second; b_num = chroma;
      end
      SecBlueMag: begin
        r_num = second; g_num = 0; b_num = chroma;
      end
      default: begin
        r_num = chroma; g_num = 0; b_num = second;
      end
    endcase
    res.red   = clamp_channel(r_num + base);
    res.green = clamp_channel(g_num + base);
    res.blue  = clamp_channel(b_num + base);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_cfg = '0;
      sat_cfg = '0;
      pending_pixels.delete();
      mismatches = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (cfg_reg_e'(paddr[ApbAw-1:2]) == RegHue) hue_cfg = pwdata[CfgW-1:0];
        else sat_cfg = pwdata[CfgW-1:0];
      end
      // retire the oldest expectation before queuing this cycle's input transfer
      if (pix_o.valid && pix_o.ready) begin
        got = '{pix_o.red_out, pix_o.green_out, pix_o.blue_out};
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                   got.red, got.green, got.blue);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
            mismatches++;
          end
        end
      end
      if (pix_i.valid && pix_i.ready)
        pending_pixels.push_back(colorize('{pix_i.red_in, pix_i.green_in, pix_i.blue_in},
                                          hue_cfg, sat_cfg));
      errors_o <= mismatches;
      pending_o <= pending_pixels.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Testbench top: clock, reset, register writes, pixel stimulus and the final verdict.
`timescale 1ns / 100ps

module tb_top;
  import phss_pkg::*;

  localparam int PhaseItems  = 150;
  localparam int NumPhases   = 12;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;
  int               errors;
  int               pending;
  int               src_idle_pct;
  int               snk_idle_pct;
  bit               hold_req;
  logic [CfgW-1:0]  cur_hue;
  logic [CfgW-1:0]  cur_sat;

  phss_in_if  pix_in ();
  phss_out_if pix_out ();

  pixel_hue_saturation_set_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_in),
    .pix_o   (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tb_colorize_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_in),
    .pix_o     (pix_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pix_out.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        pix_out.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                            input logic [ChanW-1:0] b);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= r;
    pix_in.green_in <= g;
    pix_in.blue_in  <= b;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAw'(4 * int'(idx));
    // upper data bits are junk; only the low field is kept
    pwdata  <= {(ApbDw - CfgW)'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgW-1:0] hue, input logic [CfgW-1:0] sat);
    wait_drained();
    apb_write(RegHue, hue);
    apb_write(RegSat, sat);
    cur_hue = hue;
    cur_sat = sat;
  endtask

  task automatic send_directed(input logic [CfgW-1:0] hue, input logic [CfgW-1:0] sat,
                               input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                               input logic [ChanW-1:0] b);
    if (hue != cur_hue || sat != cur_sat) configure(hue, sat);
    send_pixel(r, g, b);
  endtask

  function automatic logic [CfgW-1:0] pick_cfg();
    case ($urandom_range(4))
      0: return '0;
      1: return CfgW'(100);
      2: return '1;
      default: return CfgW'($urandom_range(127));
    endcase
  endfunction

  initial begin
    logic [ChanW-1:0] ch [3];
    int               kind;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix_in.valid    <= 1'b0;
    pix_in.red_in   <= '0;
    pix_in.green_in <= '0;
    pix_in.blue_in  <= '0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req = 1'b0;
    cur_hue = '0;
    cur_sat = '0;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset values: output is a gray of the peak
    send_directed(0, 0, 8'd0, 8'd0, 8'd0);
    send_directed(0, 0, 8'd255, 8'd255, 8'd255);
    send_directed(0, 0, 8'd255, 8'd0, 8'd0);
    send_directed(0, 0, 8'd0, 8'd0, 8'd255);
    // one pass through each of the first five sectors
    send_directed(0, 100, 8'd255, 8'd255, 8'd255);
    send_directed(0, 100, 8'd0, 8'd128, 8'd7);
    send_directed(17, 127, 8'd255, 8'd0, 8'd0);
    send_directed(17, 127, 8'd200, 8'd100, 8'd50);
    send_directed(34, 100, 8'd1, 8'd2, 8'd3);
    send_directed(50, 50, 8'd128, 8'd128, 8'd128);
    send_directed(67, 100, 8'd0, 8'd255, 8'd0);
    send_directed(83, 100, 8'd255, 8'd1, 8'd254);
    // last sector: just past 300 degrees, 360 degrees, and beyond the scale
    send_directed(84, 100, 8'd255, 8'd1, 8'd254);
    send_directed(100, 100, 8'd255, 8'd255, 8'd255);
    send_directed(100, 100, 8'd0, 8'd0, 8'd0);
    send_directed(127, 127, 8'd255, 8'd170, 8'd85);
    send_directed(127, 0, 8'd99, 8'd33, 8'd11);
    send_directed(10, 127, 8'd255, 8'd128, 8'd0);
    send_directed(49, 101, 8'd128, 8'd127, 8'd255);

    for (int phase = 0; phase < NumPhases; phase++) begin
      configure(pick_cfg(), pick_cfg());
      case (phase % 4)
        0: begin
          src_idle_pct = 0; snk_idle_pct = 0;
        end
        1: begin
          src_idle_pct = 75; snk_idle_pct = 0;
        end
        2: begin
          src_idle_pct = 0; snk_idle_pct = 75;
        end
        default: begin
          src_idle_pct = 7; snk_idle_pct = 7;
        end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (phase == 4) hold_req = 1'b1;
      repeat (PhaseItems) begin
        kind = $urandom_range(9);
        for (int i = 0; i < 3; i++)
          ch[i] = (kind == 0) ? ($urandom_range(1) ? 8'hff : 8'h00) : ChanW'($urandom());
        if (kind == 1) begin
          ch[1] = ch[0];
          ch[2] = ch[0];
        end
        send_pixel(ch[0], ch[1], ch[2]);
      end
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
